// ----- rtl/mpl_pkg.sv -----
// Shared types, constants and saturating helpers for the motor power limit current solver.
package mpl_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_W     = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_COEF_CURRENT_SPEED   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_SPEED_SQUARED   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_CURRENT_SQUARED = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_OFFSET         = CFG_IDX_W'(3);

    // Q1.15 unity of the power factor
    localparam logic [15:0] FACTOR_ONE = 16'h8000;

    localparam logic signed [63:0] WMAX   = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] WMAX_W = 65'sh0_3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S32MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] S32MIN = -64'sh0000_0000_8000_0000;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_MUL_Q15,
        OP_DIV,
        OP_SQRT
    } op_t;

    typedef struct packed {
        logic start;
        op_t  op;
    } alu_req_t;

    typedef enum logic [1:0] {
        LIM_HELD,
        LIM_ZEROED,
        LIM_ROOT,
        LIM_K2_ZERO
    } lim_status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_T0A,
        S_T0B,
        S_T1A,
        S_T1B,
        S_T2A,
        S_T2B,
        S_SUM1,
        S_SUM2,
        S_B,
        S_FP,
        S_BB,
        S_KC,
        S_DEC,
        S_SQRT,
        S_R1,
        S_R2,
        S_PICK,
        S_OUT
    } state_t;

    function automatic logic [63:0] mag(input logic signed [63:0] a);
        return a[63] ? 64'(-a) : 64'(a);
    endfunction

    function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s > WMAX_W) return WMAX;
        if (s < -WMAX_W) return -WMAX;
        return s[63:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] a);
        if (a > S32MAX) return 32'sh7FFF_FFFF;
        if (a < S32MIN) return -32'sh8000_0000;
        return a[31:0];
    endfunction

endpackage

// ----- rtl/motor_power_limit_current_solver.sv -----
// Top level: power model estimate and quadratic current limit solver.
//
//  channel | ports                                   | direction
//  s_      | s_valid/s_ready, current, speed, factor | in
//  m_      | m_valid/m_ready, limit, power, status   | out
//  cfg_    | cfg_valid/cfg_ready, cfg_index, data    | in, always ready
//
// One word at a time: s_ready is high only in idle. Every multiply, divide and
// square root runs on one bit-serial unit; an item ends after the power model
// when no limit applies, after the discriminant test when that test decides, and
// after both roots when they are solved. The result register frees the solver
// while the word waits on m_ready. Reset is synchronous and clears the held
// target and the coefficients.
module motor_power_limit_current_solver import mpl_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [15:0]   s_motor_current,
    input  logic signed [31:0]   s_shaft_speed,
    input  logic [15:0]          s_power_factor,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [31:0]   m_current_limit,
    output logic signed [31:0]   m_model_power,
    output logic [1:0]           m_limit_status,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    state_t state_reg, state_next;
    logic   issued_reg;
    logic   m_valid_reg;

    logic signed [31:0] k0_reg, k1_reg, k2_reg, off_reg;
    logic signed [31:0] held_reg;
    lim_status_t        status_reg;

    logic signed [63:0] cur_reg, w_reg;
    logic [15:0]        fac_reg;
    logic signed [63:0] tmp_reg, t0_reg, t1_reg, t2_reg, pw_reg;
    logic signed [63:0] b_reg, c_reg, delta_reg, r1_reg;

    logic signed [31:0] out_target_reg, out_power_reg;
    lim_status_t        out_status_reg;

    alu_req_t           alu_req;
    logic signed [63:0] alu_a, alu_b;
    logic               alu_done;
    logic signed [63:0] alu_res;

    logic signed [63:0] k0_w, k1_w, k2_w, off_w, pw_sum;
    logic               op_state, out_load, limit_on;
    logic               r1_pos, r1_neg, r2_pos, r2_neg, held_pos, held_neg, same_sign;
    logic signed [63:0] pick;

    assign k0_w  = 64'(k0_reg);
    assign k1_w  = 64'(k1_reg);
    assign k2_w  = 64'(k2_reg);
    assign off_w = 64'(off_reg);

    assign pw_sum   = sadd(pw_reg, t2_reg);
    assign limit_on = !pw_sum[63] && (pw_sum != '0) && (fac_reg < FACTOR_ONE);
    assign out_load = (state_reg == S_OUT) && (!m_valid_reg || m_ready);

    mpl_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .a       (alu_a),
        .b       (alu_b),
        .done    (alu_done),
        .result  (alu_res)
    );

    // root choice
    always_comb begin
        r1_pos    = !r1_reg[63] && (r1_reg != '0);
        r1_neg    = r1_reg[63];
        r2_pos    = !tmp_reg[63] && (tmp_reg != '0);
        r2_neg    = tmp_reg[63];
        held_pos  = !held_reg[31] && (held_reg != '0);
        held_neg  = held_reg[31];
        same_sign = (held_pos && r1_pos) || (held_neg && r1_neg);
        if ((r1_pos && r2_neg) || (r1_neg && r2_pos)) begin
            pick = same_sign ? r1_reg : tmp_reg;
        end else begin
            pick = (mag(r1_reg) < mag(tmp_reg)) ? r1_reg : tmp_reg;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_valid) state_next = S_T0A;
            S_T0A:  if (alu_done) state_next = S_T0B;
            S_T0B:  if (alu_done) state_next = S_T1A;
            S_T1A:  if (alu_done) state_next = S_T1B;
            S_T1B:  if (alu_done) state_next = S_T2A;
            S_T2A:  if (alu_done) state_next = S_T2B;
            S_T2B:  if (alu_done) state_next = S_SUM1;
            S_SUM1: state_next = S_SUM2;
            S_SUM2: state_next = limit_on ? S_B : S_OUT;
            S_B:    if (alu_done) state_next = S_FP;
            S_FP:   if (alu_done) state_next = S_BB;
            S_BB:   if (alu_done) state_next = S_KC;
            S_KC:   if (alu_done) state_next = S_DEC;
            S_DEC: begin
                if (delta_reg[63] || k2_reg == '0) state_next = S_OUT;
                else                                 state_next = S_SQRT;
            end
            S_SQRT: if (alu_done) state_next = S_R1;
            S_R1:   if (alu_done) state_next = S_R2;
            S_R2:   if (alu_done) state_next = S_PICK;
            S_PICK: state_next = S_OUT;
            S_OUT:  if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        op_state = 1'b1;
        alu_req.op = OP_MUL;
        alu_a = '0;
        alu_b = '0;
        unique case (state_reg)
            S_T0A:  begin alu_a = k0_w;    alu_b = cur_reg; end
            S_T0B:  begin alu_a = tmp_reg; alu_b = w_reg;   end
            S_T1A:  begin alu_a = k1_w;    alu_b = w_reg;   end
            S_T1B:  begin alu_a = tmp_reg; alu_b = w_reg;   end
            S_T2A:  begin alu_a = k2_w;    alu_b = cur_reg; end
            S_T2B:  begin alu_a = tmp_reg; alu_b = cur_reg; end
            S_B:    begin alu_a = k0_w;    alu_b = w_reg;   end
            S_FP: begin
                alu_req.op = OP_MUL_Q15;
                alu_a = 64'(fac_reg);
                alu_b = pw_reg;
            end
            S_BB:   begin alu_a = b_reg;    alu_b = b_reg; end
            S_KC:   begin alu_a = k2_w <<< 2; alu_b = c_reg; end
            S_SQRT: begin alu_req.op = OP_SQRT; alu_a = delta_reg; end
            S_R1: begin
                alu_req.op = OP_DIV;
                alu_a = sadd(-b_reg, tmp_reg);
                alu_b = k2_w <<< 1;
            end
            S_R2: begin
                alu_req.op = OP_DIV;
                alu_a = sadd(-b_reg, -tmp_reg);
                alu_b = k2_w <<< 1;
            end
            default: op_state = 1'b0;
        endcase
        alu_req.start = op_state && !issued_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            issued_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            k0_reg      <= '0;
            k1_reg      <= '0;
            k2_reg      <= '0;
            off_reg     <= '0;
            held_reg    <= '0;
            status_reg  <= LIM_HELD;
        end else begin
            state_reg <= state_next;
            if (alu_req.start)  issued_reg <= 1'b1;
            else if (alu_done)  issued_reg <= 1'b0;

            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_COEF_CURRENT_SPEED:   k0_reg  <= cfg_data;
                    CFG_COEF_SPEED_SQUARED:   k1_reg  <= cfg_data;
                    CFG_COEF_CURRENT_SQUARED: k2_reg  <= cfg_data;
                    CFG_POWER_OFFSET:         off_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (out_load)     m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE: begin
                    status_reg <= LIM_HELD;
                    if (s_valid) begin
                        cur_reg <= 64'(s_motor_current) <<< FRAC_BITS;
                        w_reg   <= 64'(s_shaft_speed);
                        fac_reg <= s_power_factor;
                    end
                end
                S_T0A, S_T1A, S_T2A, S_BB, S_SQRT, S_R2:
                    if (alu_done) tmp_reg <= alu_res;
                S_T0B: if (alu_done) t0_reg <= alu_res;
                S_T1B: if (alu_done) t1_reg <= alu_res;
                S_T2B: if (alu_done) t2_reg <= alu_res;
                S_SUM1: begin
                    pw_reg <= sadd(t0_reg, t1_reg);
                    t2_reg <= sadd(t2_reg, off_w);
                    t1_reg <= sadd(off_w, t1_reg);
                end
                S_SUM2: pw_reg <= pw_sum;
                S_B:    if (alu_done) b_reg <= alu_res;
                S_FP:   if (alu_done) c_reg <= sadd(t1_reg, -alu_res);
                S_KC:   if (alu_done) delta_reg <= sadd(tmp_reg, -alu_res);
                S_DEC: begin
                    if (delta_reg[63]) begin
                        held_reg   <= '0;
                        status_reg <= LIM_ZEROED;
                    end else if (k2_reg == '0) begin
                        status_reg <= LIM_K2_ZERO;
                    end
                end
                S_R1:   if (alu_done) r1_reg <= alu_res;
                S_PICK: begin
                    held_reg   <= sat32(pick);
                    status_reg <= LIM_ROOT;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_target_reg <= held_reg;
            out_power_reg  <= sat32(pw_reg);
            out_status_reg <= status_reg;
        end
    end

    assign s_ready         = (state_reg == S_IDLE);
    assign cfg_ready       = 1'b1;
    assign m_valid         = m_valid_reg;
    assign m_current_limit = out_target_reg;
    assign m_model_power   = out_power_reg;
    assign m_limit_status  = out_status_reg;

endmodule

// ----- rtl/mpl_alu.sv -----
// Shared bit-serial unit: scaled multiply, fixed point divide and square root.
module mpl_alu import mpl_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  alu_req_t            req,
    input  logic signed [63:0]  a,
    input  logic signed [63:0]  b,
    output logic                done,
    output logic signed [63:0]  result
);

    logic               busy_reg;
    logic               fin_reg;
    logic               done_reg;
    op_t                op_reg;
    logic [6:0]         cnt_reg;
    logic               neg_reg;
    logic [65:0]        acc_reg;
    logic [127:0]       sr_reg;
    logic [63:0]        mc_reg;
    logic signed [63:0] res_reg;

    logic [63:0]  a_mag, b_mag;
    logic [127:0] a_scaled;
    logic [64:0]  mul_sum;
    logic [64:0]  div_rem;
    logic         div_ge;
    logic [65:0]  sq_rem, sq_trial;
    logic         sq_ge;
    logic         last;
    logic [127:0] prod, mag_q;
    logic [63:0]  mag_sat;

    assign a_mag    = mag(a);
    assign b_mag    = mag(b);
    assign a_scaled = {64'd0, a_mag} << FRAC_BITS;

    assign mul_sum  = {1'b0, acc_reg[63:0]} + (sr_reg[0] ? {1'b0, mc_reg} : 65'd0);
    assign div_rem  = {acc_reg[63:0], sr_reg[127]};
    assign div_ge   = div_rem >= {1'b0, mc_reg};
    assign sq_rem   = {acc_reg[63:0], sr_reg[127:126]};
    assign sq_trial = {mc_reg, 2'b01};
    assign sq_ge    = sq_rem >= sq_trial;
    assign last     = cnt_reg == ((op_reg == OP_DIV) ? 7'd127 : 7'd63);

    always_comb begin
        prod = {acc_reg[63:0], sr_reg[63:0]};
        unique case (op_reg)
            OP_MUL:     mag_q = prod >> FRAC_BITS;
            OP_MUL_Q15: mag_q = prod >> 15;
            OP_DIV:     mag_q = sr_reg;
            OP_SQRT:    mag_q = {64'd0, mc_reg};
            default:    mag_q = '0;
        endcase
        mag_sat = (mag_q[127:62] != '0) ? 64'(WMAX) : mag_q[63:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg) begin
                busy_reg <= 1'b1;
                op_reg   <= req.op;
                cnt_reg  <= '0;
                acc_reg  <= '0;
                unique case (req.op)
                    OP_MUL, OP_MUL_Q15: begin
                        sr_reg  <= {64'd0, b_mag};
                        mc_reg  <= a_mag;
                        neg_reg <= a[63] ^ b[63];
                    end
                    OP_DIV: begin
                        sr_reg  <= a_scaled;
                        mc_reg  <= b_mag;
                        neg_reg <= a[63] ^ b[63];
                    end
                    default: begin
                        sr_reg  <= a_scaled;
                        mc_reg  <= '0;
                        neg_reg <= 1'b0;
                    end
                endcase
            end else if (busy_reg && !fin_reg) begin
                cnt_reg <= cnt_reg + 7'd1;
                if (last) fin_reg <= 1'b1;
                unique case (op_reg)
                    OP_MUL, OP_MUL_Q15: begin
                        acc_reg        <= {2'b00, mul_sum[64:1]};
                        sr_reg[63:0]   <= {mul_sum[0], sr_reg[63:1]};
                    end
                    OP_DIV: begin
                        acc_reg <= div_ge ? {1'b0, div_rem - {1'b0, mc_reg}} : {1'b0, div_rem};
                        sr_reg  <= {sr_reg[126:0], div_ge};
                    end
                    default: begin
                        acc_reg <= sq_ge ? sq_rem - sq_trial : sq_rem;
                        mc_reg  <= {mc_reg[62:0], sq_ge};
                        sr_reg  <= {sr_reg[125:0], 2'b00};
                    end
                endcase
            end else if (fin_reg) begin
                res_reg  <= neg_reg ? -$signed(mag_sat) : $signed(mag_sat);
                done_reg <= 1'b1;
                busy_reg <= 1'b0;
                fin_reg  <= 1'b0;
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule
